[rtl/core/bse_pkg.sv]
// Shared types, register codes and the Li-ion discharge curve for the SoC estimator.
package bse_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_OFFSET   = 3'd0,
		CFG_CLAMP_MIN = 3'd1,
		CFG_CLAMP_MAX = 3'd2,
		CFG_CRITICAL = 3'd3,
		CFG_VERY_LOW = 3'd4,
		CFG_LOW      = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		LVL_CRITICAL = 2'd0,
		LVL_VERY_LOW = 2'd1,
		LVL_LOW      = 2'd2,
		LVL_NORMAL   = 2'd3
	} level_t;

	// Field widths
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned OFFSET_W = 11;
	localparam int unsigned MV_W     = 14;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned LEVEL_W  = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 14;
	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 40;

	// Register reset values
	localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 11'sd163;
	localparam logic [MV_W-1:0]  CLAMP_MIN_RST = 14'd3000;
	localparam logic [MV_W-1:0]  CLAMP_MAX_RST = 14'd4200;
	localparam logic [PCT_W-1:0] CRITICAL_RST  = 7'd5;
	localparam logic [PCT_W-1:0] VERY_LOW_RST  = 7'd10;
	localparam logic [PCT_W-1:0] LOW_RST       = 7'd20;

	// Discharge curve
	localparam int unsigned KNOTS    = 12;
	localparam int unsigned SEG_W    = 4;
	localparam int unsigned DELTA_W  = 8;   // widest knot span is 200 mV
	localparam int unsigned MAX_RISE = 10;  // widest percent step between knots
	localparam int unsigned QUO_W    = 4;
	localparam int unsigned NUM_W    = 12;  // span * MAX_RISE fits

	localparam logic [MV_W-1:0] KNOT_MV [KNOTS] = '{
		14'd3300, 14'd3500, 14'd3600, 14'd3700, 14'd3750, 14'd3800,
		14'd3850, 14'd3900, 14'd3950, 14'd4000, 14'd4100, 14'd4200
	};
	localparam logic [PCT_W-1:0] KNOT_PCT [KNOTS] = '{
		7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
		7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
	};

endpackage

[rtl/core/bse_soc_lookup.sv]
// Piecewise-linear voltage to state-of-charge conversion over the fixed knot table.
module bse_soc_lookup (
	input  logic [bse_pkg::MV_W-1:0]  mv,
	output logic [bse_pkg::PCT_W-1:0] pct
);

	logic [bse_pkg::SEG_W-1:0]   seg;
	logic [bse_pkg::SEG_W-1:0]   seg_lo;
	logic [bse_pkg::MV_W-1:0]    span_full;
	logic [bse_pkg::MV_W-1:0]    delta_full;
	logic [bse_pkg::DELTA_W-1:0] span;
	logic [bse_pkg::DELTA_W-1:0] delta;
	logic [bse_pkg::PCT_W-1:0]   rise;
	logic [bse_pkg::NUM_W-1:0]   num;
	logic [bse_pkg::QUO_W-1:0]   quo;
	logic                        below_first;

	// Find the first knot above the voltage
	always_comb begin
		seg = bse_pkg::SEG_W'(bse_pkg::KNOTS - 1);
		for (int i = bse_pkg::KNOTS - 1; i >= 1; i--) begin
			if (mv < bse_pkg::KNOT_MV[i]) begin
				seg = bse_pkg::SEG_W'(i);
			end
		end
	end

	assign seg_lo      = seg - bse_pkg::SEG_W'(1);
	assign below_first = (mv <= bse_pkg::KNOT_MV[0]);
	assign span_full   = bse_pkg::KNOT_MV[seg] - bse_pkg::KNOT_MV[seg_lo];
	assign delta_full  = mv - bse_pkg::KNOT_MV[seg_lo];
	assign span        = span_full[bse_pkg::DELTA_W-1:0];
	assign delta       = delta_full[bse_pkg::DELTA_W-1:0];
	assign rise        = bse_pkg::KNOT_PCT[seg] - bse_pkg::KNOT_PCT[seg_lo];
	assign num         = bse_pkg::NUM_W'(delta) * bse_pkg::NUM_W'(rise)
	                   + bse_pkg::NUM_W'(span >> 1);

	// Quotient never exceeds the step, so count span multiples in parallel
	always_comb begin
		quo = '0;
		for (int j = 1; j <= bse_pkg::MAX_RISE; j++) begin
			if (num >= bse_pkg::NUM_W'(j) * bse_pkg::NUM_W'(span)) begin
				quo = quo + bse_pkg::QUO_W'(1);
			end
		end
	end

	always_comb begin
		priority if (below_first) begin
			pct = bse_pkg::KNOT_PCT[0];
		end else if (mv >= bse_pkg::KNOT_MV[bse_pkg::KNOTS-1]) begin
			pct = bse_pkg::KNOT_PCT[bse_pkg::KNOTS-1];
		end else begin
			pct = bse_pkg::KNOT_PCT[seg_lo] + bse_pkg::PCT_W'(quo);
		end
	end

endmodule

[rtl/core/battery_soc_estimator.sv]
// Battery state-of-charge estimator: EMA filter, divider scaling, clamp, SoC lookup, level.
//
//  channel   | dir | handshake                     | payload
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | adc_sample_mv
//  m_axis    | out | m_axis_tvalid / m_axis_tready | filtered, battery mV, percent, level
//  cfg       | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// One sample per cycle sustained while m_axis is not stalled; a taken beat passes through the
// input register, then EMA/scale/clamp into stage 2, then lookup/level into the output register.
// arst_n clears all valid flags, the EMA state and the configuration registers to their defaults.
// A stall on m_axis holds the output register; upstream stages keep filling until full.
// cfg_ready is always high; a write updates its register in the following cycle.
module battery_soc_estimator #(
	parameter int unsigned ADC_BITS    = 12,
	parameter int unsigned FRAC_BITS   = 8,
	parameter int unsigned ALPHA_SHIFT = 2
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [bse_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [11:0] adc_sample_mv

	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [11:0] filtered_adc_mv, [25:12] batt_mv, [32:26] charge_percent, [34:33] charge_level
	output logic [bse_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,

	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bse_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bse_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int unsigned ACC_W  = ADC_BITS + FRAC_BITS;
	localparam int unsigned EXT_W  = (ADC_BITS > bse_pkg::SAMPLE_W) ? ADC_BITS : bse_pkg::SAMPLE_W;
	localparam int unsigned BATT_W = EXT_W + 3;
	localparam logic [ACC_W-1:0]   HALF_LSB   = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic [ACC_W+1:0]   TRUNC_BIAS = (ACC_W+2)'((1 << ALPHA_SHIFT) - 1);
	localparam logic [ACC_W-1:0]   MAX_TARGET = {{ADC_BITS{1'b1}}, {FRAC_BITS{1'b0}}};

	// Configuration registers
	logic signed [bse_pkg::OFFSET_W-1:0] offset_q;
	logic [bse_pkg::MV_W-1:0]            clamp_min_q;
	logic [bse_pkg::MV_W-1:0]            clamp_max_q;
	logic [bse_pkg::PCT_W-1:0]           critical_q;
	logic [bse_pkg::PCT_W-1:0]           very_low_q;
	logic [bse_pkg::PCT_W-1:0]           low_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= bse_pkg::OFFSET_RST;
			clamp_min_q <= bse_pkg::CLAMP_MIN_RST;
			clamp_max_q <= bse_pkg::CLAMP_MAX_RST;
			critical_q  <= bse_pkg::CRITICAL_RST;
			very_low_q  <= bse_pkg::VERY_LOW_RST;
			low_q       <= bse_pkg::LOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bse_pkg::CFG_OFFSET:    offset_q    <= $signed(cfg_data[bse_pkg::OFFSET_W-1:0]);
				bse_pkg::CFG_CLAMP_MIN: clamp_min_q <= cfg_data;
				bse_pkg::CFG_CLAMP_MAX: clamp_max_q <= cfg_data;
				bse_pkg::CFG_CRITICAL:  critical_q  <= cfg_data[bse_pkg::PCT_W-1:0];
				bse_pkg::CFG_VERY_LOW:  very_low_q  <= cfg_data[bse_pkg::PCT_W-1:0];
				bse_pkg::CFG_LOW:       low_q       <= cfg_data[bse_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage advance: each stage moves when empty or when the next one moves
	logic v_s1, v_s2, out_v_q;
	logic adv_out, adv_s2, adv_s1;

	assign adv_out       = !out_v_q || m_axis_tready;
	assign adv_s2        = !v_s2 || adv_out;
	assign adv_s1        = !v_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign m_axis_tvalid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1)  v_s1    <= s_axis_tvalid;
			if (adv_s2)  v_s2    <= v_s1;
			if (adv_out) out_v_q <= v_s2;
		end
	end

	// Input register
	logic [EXT_W-1:0]    in_ext;
	logic [ADC_BITS-1:0] sample_s1;

	assign in_ext = EXT_W'(s_axis_tdata[bse_pkg::SAMPLE_W-1:0]);

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= in_ext[ADC_BITS-1:0];
		end
	end

	// EMA update: step truncates toward zero, so bias negative differences
	logic [ACC_W-1:0]        acc_q;
	logic                    loaded_q;
	logic [ACC_W-1:0]        target;
	logic signed [ACC_W+1:0] diff;
	logic signed [ACC_W+1:0] bias;
	logic signed [ACC_W+1:0] step;
	logic signed [ACC_W+1:0] acc_sum;
	logic [ACC_W-1:0]        acc_next;
	logic [ACC_W-1:0]        acc_rnd;
	logic [ADC_BITS-1:0]     filt;
	logic [EXT_W-1:0]        filt_ext;
	logic signed [BATT_W-1:0] batt_raw;
	logic [bse_pkg::MV_W-1:0] batt_clamped;
	logic                    ema_adv;

	assign ema_adv  = v_s1 && adv_s2;
	assign target   = {sample_s1, {FRAC_BITS{1'b0}}};
	assign diff     = $signed({2'b00, target}) - $signed({2'b00, acc_q});
	assign bias     = diff[ACC_W+1] ? $signed(TRUNC_BIAS) : '0;
	assign step     = (diff + bias) >>> ALPHA_SHIFT;
	assign acc_sum  = $signed({2'b00, acc_q}) + step;
	assign acc_next = loaded_q ? acc_sum[ACC_W-1:0] : target;
	assign acc_rnd  = acc_next + HALF_LSB;
	assign filt     = acc_rnd[ACC_W-1:FRAC_BITS];
	assign filt_ext = EXT_W'(filt);
	assign batt_raw = $signed(BATT_W'(filt_ext) + (BATT_W'(filt_ext) << 1))
	                + BATT_W'(offset_q);

	// Minimum is tested first, so with inverted bounds below min gives min and anything else gives max
	always_comb begin
		priority if (batt_raw < $signed(BATT_W'(clamp_min_q))) begin
			batt_clamped = clamp_min_q;
		end else if (batt_raw > $signed(BATT_W'(clamp_max_q))) begin
			batt_clamped = clamp_max_q;
		end else begin
			batt_clamped = batt_raw[bse_pkg::MV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			loaded_q <= 1'b0;
		end else if (ema_adv) begin
			acc_q    <= acc_next;
			loaded_q <= 1'b1;
		end
	end

	logic [bse_pkg::SAMPLE_W-1:0] filt_s2;
	logic [bse_pkg::MV_W-1:0]     batt_s2;

	always_ff @(posedge clk) begin
		if (ema_adv) begin
			filt_s2 <= filt_ext[bse_pkg::SAMPLE_W-1:0];
			batt_s2 <= batt_clamped;
		end
	end

	// Lookup and level
	logic [bse_pkg::PCT_W-1:0] pct;
	bse_pkg::level_t           level;

	bse_soc_lookup u_lookup (
		.mv  (batt_s2),
		.pct (pct)
	);

	always_comb begin
		priority if (pct <= critical_q) begin
			level = bse_pkg::LVL_CRITICAL;
		end else if (pct <= very_low_q) begin
			level = bse_pkg::LVL_VERY_LOW;
		end else if (pct <= low_q) begin
			level = bse_pkg::LVL_LOW;
		end else begin
			level = bse_pkg::LVL_NORMAL;
		end
	end

	logic [bse_pkg::SAMPLE_W-1:0] filt_q;
	logic [bse_pkg::MV_W-1:0]     batt_q;
	logic [bse_pkg::PCT_W-1:0]    pct_q;
	bse_pkg::level_t              level_q;

	always_ff @(posedge clk) begin
		if (v_s2 && adv_out) begin
			filt_q  <= filt_s2;
			batt_q  <= batt_s2;
			pct_q   <= pct;
			level_q <= level;
		end
	end

	assign m_axis_tdata = {5'b00000, level_q, pct_q, batt_q, filt_q};

	// Checks
	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q <= MAX_TARGET)
		else $error("EMA accumulator above largest target");

	a_unloaded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!loaded_q |-> acc_q == '0)
		else $error("EMA accumulator moved before first sample");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> pct_q <= bse_pkg::KNOT_PCT[bse_pkg::KNOTS-1])
		else $error("charge percent above full scale");

	a_load_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		ema_adv |=> loaded_q && v_s2)
		else $error("sample left input stage without EMA update");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for battery_soc_estimator: stream stimulus, register phases and a scoreboard.
module tb;
	import bse_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int CURVE_KNOTS  = 12;
	localparam int CURVE_MV [CURVE_KNOTS] = '{
		3300, 3500, 3600, 3700, 3750, 3800, 3850, 3900, 3950, 4000, 4100, 4200
	};
	localparam int CURVE_PCT [CURVE_KNOTS] = '{
		0, 5, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
	};

	typedef struct packed {
		level_t             level;
		logic [PCT_W-1:0]   pct;
		logic [MV_W-1:0]    batt;
		logic [SAMPLE_W-1:0] filt;
	} soc_result_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // [11:0] adc_sample_mv
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [11:0] filtered_adc_mv, [25:12] batt_mv, [32:26] charge_percent, [34:33] charge_level
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// mirror of the block's registers and filter state
	logic signed [OFFSET_W-1:0] cur_offset = OFFSET_RST;
	logic [MV_W-1:0]  cur_min = CLAMP_MIN_RST;
	logic [MV_W-1:0]  cur_max = CLAMP_MAX_RST;
	logic [PCT_W-1:0] cur_crit = CRITICAL_RST;
	logic [PCT_W-1:0] cur_vlow = VERY_LOW_RST;
	logic [PCT_W-1:0] cur_low = LOW_RST;
	logic [SAMPLE_W+7:0] ema_acc = '0;
	bit ema_primed = 1'b0;

	soc_result_t soc_expected [$];
	int n_errors = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_settings = 0;
	int n_cycles = 0;
	int burst_left = 0;
	int gap_pending = 0;
	bit gaps_on = 1'b1;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_tick = 0;
	int rx_hold = 0;

	battery_soc_estimator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Filter, scale, clamp, curve lookup and level for one accepted sample.
	function automatic soc_result_t estimate_soc(input logic [SAMPLE_W-1:0] mv);
		int target;
		int filt;
		int volts;
		int pct;
		int span;
		soc_result_t r;
		target = int'(mv) * 256;
		if (!ema_primed) begin
			ema_acc = 20'(target);
			ema_primed = 1'b1;
		end else begin
			// signed divide truncates toward zero, as the filter does
			ema_acc = 20'(int'(ema_acc) + (target - int'(ema_acc)) / 4);
		end
		filt = (int'(ema_acc) + 128) / 256;
		volts = filt * 3 + int'(cur_offset);
		if (volts < int'(cur_min))
			volts = int'(cur_min);
		else if (volts > int'(cur_max))
			volts = int'(cur_max);
		pct = 100;
		if (volts <= CURVE_MV[0]) begin
			pct = 0;
		end else begin
			for (int k = 1; k < CURVE_KNOTS; k++) begin
				if (volts < CURVE_MV[k]) begin
					span = CURVE_MV[k] - CURVE_MV[k-1];
					pct = CURVE_PCT[k-1] + ((volts - CURVE_MV[k-1]) *
						(CURVE_PCT[k] - CURVE_PCT[k-1]) + span / 2) / span;
					break;
				end
			end
		end
		if (pct <= int'(cur_crit))
			r.level = LVL_CRITICAL;
		else if (pct <= int'(cur_vlow))
			r.level = LVL_VERY_LOW;
		else if (pct <= int'(cur_low))
			r.level = LVL_LOW;
		else
			r.level = LVL_NORMAL;
		r.filt = 12'(filt);
		r.batt = 14'(volts);
		r.pct = 7'(pct);
		return r;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic int clip_sample(input int v);
		if (v < 0)
			return 0;
		if (v > 4095)
			return 4095;
		return v;
	endfunction

	// Scoreboard: compare every output beat with the oldest prediction.
	always @(posedge clk) begin
		soc_result_t got;
		soc_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[34:0];
			if (soc_expected.size() == 0) begin
				n_errors++;
				$display("%0t: result beat with nothing expected, expected none actual %h",
					$time, m_axis_tdata);
			end else begin
				want = soc_expected.pop_front();
				n_results++;
				check_field("filtered_adc_mv", want.filt, got.filt);
				check_field("batt_mv", want.batt, got.batt);
				check_field("charge_percent", want.pct, got.pct);
				check_field("charge_level", int'(want.level), int'(got.level));
			end
		end
	end

	// Output back-pressure: switch between stall patterns at random intervals.
	always @(posedge clk) begin
		if (rx_tick == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_tick = $urandom_range(50, 300);
		end else begin
			rx_tick--;
		end
		case (rx_mode)
			RX_OPEN: begin
				m_axis_tready <= 1'b1;
			end
			RX_COIN: begin
				m_axis_tready <= 1'($urandom_range(0, 1));
			end
			RX_SPARSE: begin
				m_axis_tready <= (rx_tick % 4 == 0);
			end
			default: begin
				if (rx_hold == 0) begin
					rx_hold = $urandom_range(1, 20);
					m_axis_tready <= ~m_axis_tready;
				end else begin
					rx_hold--;
				end
			end
		endcase
	end

	// Send one sample beat; the sender runs in bursts with random gaps between them.
	task automatic send_sample(input int mv);
		repeat (gap_pending) @(posedge clk);
		gap_pending = 0;
		if (burst_left == 0)
			burst_left = $urandom_range(1, 40);
		s_axis_tdata <= {4'b0000, 12'(mv)};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		soc_expected.push_back(estimate_soc(12'(mv)));
		n_samples++;
		burst_left--;
		if (burst_left == 0 && gaps_on && $urandom_range(0, 3) != 0) begin
			gap_pending = $urandom_range(1, 8);
			s_axis_tvalid <= 1'b0;
		end
	endtask

	// Hold off the sender until every predicted result has come back.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		gap_pending = 0;
		@(posedge clk);
		while (soc_expected.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input int offset, input int cmin, input int cmax,
			input int crit, input int vlow, input int low);
		wait_idle();
		write_reg(CFG_OFFSET, {3'b000, 11'(offset)});
		write_reg(CFG_CLAMP_MIN, 14'(cmin));
		write_reg(CFG_CLAMP_MAX, 14'(cmax));
		write_reg(CFG_CRITICAL, {7'b0, 7'(crit)});
		write_reg(CFG_VERY_LOW, {7'b0, 7'(vlow)});
		write_reg(CFG_LOW, {7'b0, 7'(low)});
		cfg_valid <= 1'b0;
		cur_offset = 11'(offset);
		cur_min = 14'(cmin);
		cur_max = 14'(cmax);
		cur_crit = 7'(crit);
		cur_vlow = 7'(vlow);
		cur_low = 7'(low);
		n_settings++;
	endtask

	// Reset defaults; the first sample loads the filter directly.
	task automatic test_first_load();
		send_sample(4095);
		send_sample(4095);
		send_sample(0);
		send_sample(0);
		send_sample(1100);
		send_sample(1400);
	endtask

	// Open clamp window: below the first knot and above the last one.
	task automatic test_curve_ends();
		program_regs(0, 0, 16383, 5, 10, 20);
		send_sample(0);
		send_sample(0);
		send_sample(4095);
		send_sample(4095);
		send_sample(4095);
	endtask

	task automatic test_offset_extremes();
		program_regs(-1024, 0, 16383, 5, 10, 20);
		send_sample(0);
		send_sample(0);
		program_regs(1023, 0, 16383, 5, 10, 20);
		send_sample(4095);
		send_sample(4095);
	endtask

	// Minimum above maximum: below min gives min, anything else gives max.
	task automatic test_inverted_clamp();
		program_regs(163, 4000, 3400, 5, 10, 20);
		send_sample(0);
		send_sample(0);
		send_sample(4095);
		send_sample(4095);
	endtask

	// Thresholds out of order and above 100; the first match in order wins.
	task automatic test_thresholds();
		program_regs(163, 3000, 4200, 127, 0, 50);
		send_sample(1200);
		send_sample(1300);
		program_regs(163, 3000, 4200, 0, 127, 100);
		send_sample(1250);
		send_sample(1350);
		program_regs(163, 3000, 4200, 0, 0, 0);
		send_sample(1400);
	endtask

	// Phases of random settings, mostly held voltages that let the filter settle.
	task automatic test_random_tracking();
		int offset;
		int cmin;
		int cmax;
		int crit;
		int vlow;
		int low;
		int sent_here;
		int hold;
		int base;
		int noise;
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 0) begin
				program_regs(OFFSET_RST, CLAMP_MIN_RST, CLAMP_MAX_RST,
					CRITICAL_RST, VERY_LOW_RST, LOW_RST);
			end else begin
				case ($urandom_range(0, 9))
					0: offset = -1024;
					1: offset = 1023;
					2: offset = $urandom_range(0, 2047) - 1024;
					default: offset = $urandom_range(0, 400) - 100;
				endcase
				case ($urandom_range(0, 9))
					0: cmin = 0;
					1: cmin = 16383;
					2: cmin = $urandom_range(0, 16383);
					default: cmin = $urandom_range(2800, 3500);
				endcase
				case ($urandom_range(0, 9))
					0: cmax = 0;
					1: cmax = 16383;
					2: cmax = $urandom_range(0, 16383);
					default: cmax = $urandom_range(3900, 4500);
				endcase
				if ($urandom_range(0, 4) == 0) begin
					crit = $urandom_range(0, 127);
					vlow = $urandom_range(0, 127);
					low = $urandom_range(0, 127);
				end else begin
					crit = $urandom_range(0, 30);
					vlow = crit + $urandom_range(0, 30);
					low = vlow + $urandom_range(0, 40);
				end
				program_regs(offset, cmin, cmax, crit, vlow, low);
			end
			gaps_on = (phase % 3 != 1);
			sent_here = 0;
			while (sent_here < 100) begin
				case ($urandom_range(0, 9))
					0: begin
						send_sample($urandom_range(0, 4095));
						sent_here++;
					end
					1: begin
						hold = $urandom_range(1, 4);
						repeat (hold) send_sample($urandom_range(0, 1) ? 4095 : 0);
						sent_here += hold;
					end
					default: begin
						// aim at a battery voltage on the curve and hold it with jitter
						base = ($urandom_range(3150, 4350) - int'(cur_offset)) / 3;
						noise = $urandom_range(0, 4);
						hold = $urandom_range(1, 24);
						repeat (hold)
							send_sample(clip_sample(base + $urandom_range(0, 2 * noise) - noise));
						sent_here += hold;
					end
				endcase
				if ($urandom_range(0, 15) == 0)
					wait_idle();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_load();
		test_curve_ends();
		test_offset_extremes();
		test_inverted_clamp();
		test_thresholds();
		test_random_tracking();
		wait_idle();
		repeat (8) @(posedge clk);
		$display("Checked %0d results from %0d samples under %0d register settings,",
			n_results, n_samples, n_settings);
		$display("covering filter load, curve ends, clamp limits and threshold order.");
		if (n_errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/core/bse_pkg.sv
rtl/core/bse_soc_lookup.sv
rtl/core/battery_soc_estimator.sv
tb/tb.sv
